// ----- src/nbpd_pkg.sv -----
// Package for the bar pattern deduplicator: payload structs, sizes, state codes.
// No dependencies.
package nbpd_pkg;

  localparam int unsigned MaxPatterns = 256;
  localparam int unsigned Slots       = 16;
  localparam int unsigned SlotW       = $clog2(Slots);
  localparam int unsigned EntryW      = $clog2(MaxPatterns);
  localparam int unsigned CountW      = $clog2(MaxPatterns + 1);
  localparam int unsigned AddrW       = EntryW + SlotW;
  localparam int unsigned CellW       = 17;
  localparam int unsigned TimeW       = 24;
  localparam int unsigned TpqW        = 10;
  localparam int unsigned BarW        = 20;
  localparam int unsigned QuotW       = TimeW;

  localparam logic [0:0] CfgTpq   = 1'b0;
  localparam logic [0:0] CfgTrack = 1'b1;
  localparam logic [TpqW-1:0] TpqReset = 10'd48;

  typedef struct packed {
    logic        kind;
    logic [23:0] note_time;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
  } in_item_t;

  typedef struct packed {
    logic [19:0] bar_index;
    logic [7:0]  pattern_index;
    logic        is_new;
    logic        table_full;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle, StDiv, StDecide, StFlushClr, StSearch, StCmp, StNext, StStore, StWrite,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctrl_t;

endpackage

// ----- src/nbpd_div.sv -----
// Bit-serial restoring divider: note_time / ticks_per_quarter, one bit a cycle.
// Depends on nbpd_pkg.
module nbpd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nbpd_pkg::div_ctrl_t             ctrl_i,
  input  logic [nbpd_pkg::TimeW-1:0]      dividend_i,
  input  logic [nbpd_pkg::TpqW-1:0]       divisor_i,
  output logic                            done_o,
  output logic [nbpd_pkg::QuotW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(nbpd_pkg::TimeW + 1);

  logic [nbpd_pkg::TpqW:0]       rem_q, rem_d;
  logic [nbpd_pkg::TimeW-1:0]    q_q, q_d;
  logic [nbpd_pkg::TpqW-1:0]     dv_q, dv_d;
  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          run_q, run_d;
  logic [nbpd_pkg::TpqW:0]       trial;

  always_comb begin
    rem_d = rem_q; q_d = q_q; dv_d = dv_q; cnt_d = cnt_q; run_d = run_q;
    trial = {rem_q[nbpd_pkg::TpqW-1:0], q_q[nbpd_pkg::TimeW-1]};
    if (ctrl_i.start) begin
      rem_d = '0;
      q_d   = dividend_i;
      dv_d  = (divisor_i == '0) ? nbpd_pkg::TpqW'(1) : divisor_i;
      cnt_d = CntW'(nbpd_pkg::TimeW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, dv_q}) begin
        rem_d = trial - {1'b0, dv_q};
        q_d   = {q_q[nbpd_pkg::TimeW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d   = {q_q[nbpd_pkg::TimeW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    q_q   <= q_d;
    dv_q  <= dv_d;
  end

  assign done_o = ctrl_i.busy & ~run_q;
  assign quot_o = q_q;
endmodule

// ----- src/note_bar_pattern_dedup_top.sv -----
// Top level of the bar pattern deduplicator.
// Depends on nbpd_pkg and nbpd_div.
//
// Note events are quantised to quarter slots (bar = time / tpq / 16) and
// collected into a 16-slot work pattern. A note in a later bar, or an end of
// track transaction, flushes the work pattern: it is compared against each
// stored pattern, one slot of one entry per cycle from a single-port pattern
// memory, and reported as a match, a new entry, or store full. One
// transaction at a time: a note waits on the bit-serial divider, then passes
// a decide state and, unless it is dropped as late, a write of its slot. A
// flush issues, compares slot by slot and gives a verdict on each stored entry
// searched, stores a new entry slot by slot, and has set-up and output steps;
// the store holds up to 256 entries. Entry 0 is the blank pattern and is never
// read from memory, so no clearing pass is needed. The result sits in an
// output register; out_stall_i holds it, and the input stays stalled until
// it has gone.
module note_bar_pattern_dedup_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  nbpd_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nbpd_pkg::out_item_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [9:0]            cfg_data_i
);

  localparam int unsigned SW = nbpd_pkg::SlotW;
  localparam int unsigned EW = nbpd_pkg::EntryW;
  localparam int unsigned CW = nbpd_pkg::CountW;

  nbpd_pkg::state_e state_q, state_d;

  logic [nbpd_pkg::TpqW-1:0] tpq_q;
  logic [1:0]                track_q;

  nbpd_pkg::in_item_t        item_q, item_d;
  logic [nbpd_pkg::CellW-1:0] work_q [nbpd_pkg::Slots];
  logic [nbpd_pkg::BarW-1:0] bar_q, bar_d;
  logic [CW-1:0]             count_q, count_d;
  logic [CW-1:0]             ent_q, ent_d;
  logic [SW-1:0]             slot_q, slot_d;
  logic                      diff_q, diff_d;
  logic [nbpd_pkg::BarW-1:0] nbar_q, nbar_d;
  logic [SW-1:0]             nslot_q, nslot_d;
  nbpd_pkg::out_item_t       res_q, res_d;
  logic                      ov_q, ov_d;

  // pattern memory
  logic [nbpd_pkg::CellW-1:0] mem [2**nbpd_pkg::AddrW];
  logic [nbpd_pkg::CellW-1:0] rd_q;
  logic                       mem_we, mem_re;
  logic [nbpd_pkg::AddrW-1:0] mem_addr;

  logic work_clr, work_wr;

  nbpd_pkg::div_ctrl_t      dctl;
  logic                     ddone;
  logic [nbpd_pkg::QuotW-1:0] quot;

  // divider loads its dividend on the accepting edge
  nbpd_div u_div (
    .clk_i, .rst_ni, .ctrl_i(dctl),
    .dividend_i(in_data_i.note_time), .divisor_i(tpq_q),
    .done_o(ddone), .quot_o(quot)
  );

  assign in_stall_o  = (state_q != nbpd_pkg::StIdle) | ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q; item_d = item_q; bar_d = bar_q; count_d = count_q;
    ent_d = ent_q; slot_d = slot_q; diff_d = diff_q; nbar_d = nbar_q;
    nslot_d = nslot_q; res_d = res_q; ov_d = ov_q;
    dctl = '0; mem_we = 1'b0; mem_re = 1'b0; work_clr = 1'b0; work_wr = 1'b0;
    mem_addr = {ent_q[EW-1:0], slot_q};
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      nbpd_pkg::StIdle: begin
        if (in_valid_i && !ov_q) begin
          item_d = in_data_i;
          if (in_data_i.kind) state_d = nbpd_pkg::StFlushClr;
          else begin
            dctl.start = 1'b1;
            state_d = nbpd_pkg::StDiv;
          end
        end
      end
      nbpd_pkg::StDiv: begin
        dctl.busy = 1'b1;
        if (ddone) begin
          nbar_d  = quot[SW +: nbpd_pkg::BarW];
          nslot_d = quot[SW-1:0];
          state_d = nbpd_pkg::StDecide;
        end
      end
      nbpd_pkg::StDecide: begin
        if (nbar_q < bar_q) state_d = nbpd_pkg::StIdle;
        else if (nbar_q > bar_q) state_d = nbpd_pkg::StFlushClr;
        else state_d = nbpd_pkg::StWrite;
      end
      nbpd_pkg::StFlushClr: begin
        // entry 0 is blank: match if every slot is zero
        res_d.bar_index = bar_q;
        res_d.is_new = 1'b0; res_d.table_full = 1'b0; res_d.pattern_index = '0;
        ent_d = CW'(1); slot_d = '0; diff_d = 1'b0;
        state_d = nbpd_pkg::StSearch;
        for (int s = 0; s < nbpd_pkg::Slots; s++)
          if (work_q[s] != '0) diff_d = 1'b1;
      end
      nbpd_pkg::StSearch: begin
        if (!diff_q) state_d = nbpd_pkg::StOut;
        else if (ent_q >= count_q) begin
          slot_d = '0;
          if (count_q == CW'(nbpd_pkg::MaxPatterns)) begin
            res_d.table_full = 1'b1;
            state_d = nbpd_pkg::StOut;
          end else state_d = nbpd_pkg::StStore;
        end else begin
          diff_d = 1'b0; slot_d = '0;
          mem_addr = {ent_q[EW-1:0], SW'(0)};
          mem_re = 1'b1;
          state_d = nbpd_pkg::StCmp;
        end
      end
      nbpd_pkg::StCmp: begin
        if (rd_q != work_q[slot_q]) diff_d = 1'b1;
        if (slot_q == SW'(nbpd_pkg::Slots - 1)) state_d = nbpd_pkg::StNext;
        else begin
          slot_d = slot_q + SW'(1);
          mem_addr = {ent_q[EW-1:0], slot_d};
          mem_re = 1'b1;
        end
      end
      nbpd_pkg::StNext: begin
        if (!diff_q) begin
          res_d.pattern_index = ent_q[7:0];
          state_d = nbpd_pkg::StOut;
        end else begin
          ent_d = ent_q + CW'(1);
          state_d = nbpd_pkg::StSearch;
        end
      end
      nbpd_pkg::StStore: begin
        mem_we = 1'b1;
        slot_d = slot_q + SW'(1);
        if (slot_q == SW'(nbpd_pkg::Slots - 1)) begin
          res_d.pattern_index = count_q[7:0];
          res_d.is_new = 1'b1;
          count_d = count_q + CW'(1);
          state_d = nbpd_pkg::StOut;
        end
      end
      nbpd_pkg::StOut: begin
        ov_d = 1'b1;
        work_clr = 1'b1;
        if (item_q.kind) begin
          bar_d = '0;
          state_d = nbpd_pkg::StIdle;
        end else begin
          bar_d = nbar_q;
          state_d = nbpd_pkg::StWrite;
        end
      end
      nbpd_pkg::StWrite: begin
        work_wr = 1'b1;
        state_d = nbpd_pkg::StIdle;
      end
      default: state_d = nbpd_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nbpd_pkg::StIdle;
      tpq_q   <= nbpd_pkg::TpqReset;
      track_q <= '0;
      bar_q   <= '0;
      count_q <= CW'(1);
      ov_q    <= 1'b0;
      for (int s = 0; s < nbpd_pkg::Slots; s++) work_q[s] <= '0;
    end else begin
      state_q <= state_d;
      bar_q   <= bar_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        if (cfg_index_i == nbpd_pkg::CfgTpq) tpq_q <= cfg_data_i;
        else track_q <= cfg_data_i[1:0];
      end
      if (work_clr) begin
        for (int s = 0; s < nbpd_pkg::Slots; s++) work_q[s] <= '0;
      end else if (work_wr) begin
        work_q[nslot_q] <= {3'(track_q) + 3'd1, item_q.velocity, item_q.note_number};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    ent_q   <= ent_d;
    slot_q  <= slot_d;
    diff_q  <= diff_d;
    nbar_q  <= nbar_d;
    nslot_q <= nslot_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{count_q[EW-1:0], slot_q}] <= work_q[slot_q];
    if (mem_re) rd_q <= mem[mem_addr];
  end
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for note_bar_pattern_dedup_top: directed and random note/flush traffic,
// checked against an in-bench model of the bar pattern store.
// Depends on nbpd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  nbpd_pkg::in_item_t   in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b1;
  nbpd_pkg::out_item_t  out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_index_i = nbpd_pkg::CfgTpq;
  logic [9:0]           cfg_data_i = '0;

  note_bar_pattern_dedup_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Model of the block: register copies, pattern store and work pattern
  // ---------------------------------------------------------------------------
  logic [nbpd_pkg::TpqW-1:0]  m_tpq = nbpd_pkg::TpqReset;
  logic [1:0]                 m_track = '0;
  logic [nbpd_pkg::CellW-1:0] m_store [nbpd_pkg::MaxPatterns][nbpd_pkg::Slots];
  logic [nbpd_pkg::CellW-1:0] m_work [nbpd_pkg::Slots];
  int unsigned                m_count = 1;
  logic [nbpd_pkg::BarW-1:0]  m_bar = '0;

  nbpd_pkg::out_item_t assignments_q [$];   // bar assignments still to come out
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  bit          quick_mode = 0;      // no idling on either side
  int unsigned hold_req = 0;        // long receiver hold-off, in cycles

  // Search the store for the work pattern, store it if new and the store has room, queue the report.
  function automatic void flush_bar();
    nbpd_pkg::out_item_t r;
    bit found = 0;
    bit same;
    r = '0;
    r.bar_index = m_bar;
    for (int e = 0; e < m_count && !found; e++) begin
      same = 1;
      for (int s = 0; s < nbpd_pkg::Slots; s++)
        if (m_store[e][s] !== m_work[s]) same = 0;
      if (same) begin
        found = 1;
        r.pattern_index = e[7:0];
      end
    end
    if (!found) begin
      if (m_count < nbpd_pkg::MaxPatterns) begin
        for (int s = 0; s < nbpd_pkg::Slots; s++) m_store[m_count][s] = m_work[s];
        r.pattern_index = m_count[7:0];
        r.is_new = 1'b1;
        m_count++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    assignments_q.push_back(r);
    for (int s = 0; s < nbpd_pkg::Slots; s++) m_work[s] = '0;
  endfunction

  function automatic void predict_note(nbpd_pkg::in_item_t it);
    int unsigned tpq, quarters;
    logic [nbpd_pkg::BarW-1:0] bar;
    tpq = (m_tpq == 0) ? 1 : m_tpq;
    if (it.kind) begin
      flush_bar();
      m_bar = '0;
      return;
    end
    quarters = it.note_time / tpq;
    bar = nbpd_pkg::BarW'(quarters / nbpd_pkg::Slots);
    if (bar < m_bar) return;        // late note: dropped
    if (bar > m_bar) begin
      flush_bar();
      m_bar = bar;
    end
    m_work[quarters % nbpd_pkg::Slots] = {m_track + 3'd1, it.velocity, it.note_number};
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  task automatic send_item(nbpd_pkg::in_item_t it);
    int unsigned gap;
    gap = quick_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_note(it);
    items_sent++;
  endtask

  task automatic send_note(int unsigned t, int unsigned note, int unsigned vel);
    nbpd_pkg::in_item_t it;
    it.kind = 1'b0;
    it.note_time = 24'(t);
    it.note_number = 7'(note);
    it.velocity = 7'(vel);
    send_item(it);
  endtask

  task automatic send_end_of_track();
    nbpd_pkg::in_item_t it;
    it = nbpd_pkg::in_item_t'($bits(nbpd_pkg::in_item_t)'({$urandom, $urandom}));
    it.kind = 1'b1;
    send_item(it);
  endtask

  // Wait until every report is back, then let a trailing note finish.
  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (assignments_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == nbpd_pkg::CfgTpq) m_tpq = val;
    else m_track = val[1:0];
  endtask

  task automatic set_mode(int unsigned tpq, int unsigned track);
    write_reg(nbpd_pkg::CfgTpq, 10'(tpq));
    write_reg(nbpd_pkg::CfgTrack, 10'(track));
  endtask

  // Time of a note in a given bar and slot, with some jitter inside the quarter.
  function automatic int unsigned slot_time(int unsigned bar, int unsigned slot);
    int unsigned tpq;
    tpq = (m_tpq == 0) ? 1 : m_tpq;
    return (bar * nbpd_pkg::Slots + slot) * tpq + $urandom_range(0, tpq - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
      end
      n = quick_mode ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_req == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (assignments_q.size() == 0) begin
        $display("%0t: unexpected bar report %p", $time, out_data_o);
        errors++;
      end else begin
        nbpd_pkg::out_item_t exp;
        exp = assignments_q.pop_front();
        if (out_data_o.bar_index !== exp.bar_index) begin
          $display("%0t: bar_index exp %0d got %0d", $time, exp.bar_index,
                   out_data_o.bar_index);
          errors++;
        end
        if (out_data_o.pattern_index !== exp.pattern_index) begin
          $display("%0t: pattern_index exp %0d got %0d", $time, exp.pattern_index,
                   out_data_o.pattern_index);
          errors++;
        end
        if (out_data_o.is_new !== exp.is_new) begin
          $display("%0t: is_new exp %0d got %0d", $time, exp.is_new, out_data_o.is_new);
          errors++;
        end
        if (out_data_o.table_full !== exp.table_full) begin
          $display("%0t: table_full exp %0d got %0d", $time, exp.table_full,
                   out_data_o.table_full);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the fields, late notes, bar advance, end of track, zero tpq.
  task automatic test_directed();
    send_end_of_track();                          // blank bar matches entry 0
    send_note(0, 127, 127);
    send_note(15 * 48 + 47, 0, 0);                // last slot of bar 0
    send_note(16 * 48, 64, 1);                    // later bar: flush bar 0
    send_note(5, 1, 2);                           // earlier bar: dropped
    send_note(17 * 48, 42, 99);                   // same bar
    send_note(24'hFFFFFF, 127, 127);              // far later bar
    send_end_of_track();
    send_note(0, 127, 127);                       // repeat of first pattern
    send_note(15 * 48 + 47, 0, 0);
    send_end_of_track();
    drain();
    set_mode(0, 3);                               // zero tpq counts as one
    send_note(0, 10, 20);
    send_note(31, 11, 21);
    send_note(24'hFFFFFF, 12, 22);
    send_end_of_track();
    drain();
    set_mode(1023, 2);
    send_note(0, 85, 42);
    send_note(24'hFFFFFF, 42, 85);
    send_end_of_track();
    drain();
  endtask

  // Output held off for a long stretch while bars keep arriving.
  task automatic test_output_backpressure();
    set_mode(2, 1);
    hold_req = 600;
    for (int b = 0; b < 6; b++) begin
      send_note(slot_time(b, 0), 60, 100);
      send_note(slot_time(b, 4 + b % 3), 62, 90);
    end
    send_end_of_track();
    drain();
  endtask

  typedef struct {
    int unsigned n;
    int unsigned slot [4];
    int unsigned note [4];
    int unsigned vel [4];
  } groove_t;

  // Tracks built mostly from a small set of recurring bars, with noise.
  task automatic test_random_tracks(int unsigned target);
    groove_t pool [6];
    int unsigned bar, pick;
    foreach (pool[p]) begin
      pool[p].n = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
        pool[p].slot[i] = $urandom_range(0, nbpd_pkg::Slots - 1);
        pool[p].note[i] = $urandom_range(0, 127);
        pool[p].vel[i]  = $urandom_range(0, 127);
      end
    end
    while (items_sent < target) begin
      quick_mode = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       set_mode(1023, $urandom_range(0, 3));
        1:       set_mode(0, $urandom_range(0, 3));
        default: set_mode($urandom_range(1, 12), $urandom_range(0, 3));
      endcase
      bar = $urandom_range(0, 3);
      repeat ($urandom_range(2, 10)) begin
        pick = $urandom_range(0, 5);
        for (int i = 0; i < pool[pick].n; i++) begin
          send_note(slot_time(bar, pool[pick].slot[i]), pool[pick].note[i],
                    pool[pick].vel[i]);
          if ($urandom_range(0, 29) == 0)
            send_note($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 127),
                      $urandom_range(0, 127));
          if (bar > 0 && $urandom_range(0, 9) == 0)
            send_note(slot_time(bar - 1, $urandom_range(0, 15)), 7, 7);
        end
        bar += $urandom_range(1, 3);
      end
      if ($urandom_range(0, 9) == 0) send_end_of_track();
      send_end_of_track();
      drain();
      quick_mode = 0;
    end
  endtask

  // Fill the store with distinct bars, then overflow it.
  task automatic test_store_full();
    int unsigned extra = 0;
    set_mode(1, 0);
    for (int unsigned k = 0; k < 700 && extra < 6; k++) begin
      if (m_count == nbpd_pkg::MaxPatterns) extra++;
      send_note((k + 1) * nbpd_pkg::Slots + 3, k % 128, 33);
      send_note((k + 1) * nbpd_pkg::Slots + 7, (k / 128) + 100, 77);
    end
    send_end_of_track();
    send_end_of_track();                          // blank still matches entry 0
    drain();
  endtask

  initial begin
    for (int s = 0; s < nbpd_pkg::Slots; s++) begin
      m_work[s] = '0;
      for (int e = 0; e < nbpd_pkg::MaxPatterns; e++) m_store[e][s] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_backpressure();
    test_random_tracks(750);
    test_store_full();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- note_bar_pattern_dedup_top.f -----
src/nbpd_pkg.sv
src/nbpd_div.sv
src/note_bar_pattern_dedup_top.sv
tb/sv/tb.sv
